@@ hdl/assert_macros.svh @@
// Assertion macros shared by the smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

@@ hdl/wsas_pkg.sv @@
// Types and constants shared by the windowed speed adaptive smoother.
package wsas_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int POS_W = 24;
   localparam int TIME_W = 32;
   localparam int STEP_W = 25;
   localparam int CFG_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int SQRT_STEPS = 25;
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;

   localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd50000;
   localparam logic [CFG_W-1:0] FLOOR_RESET = 32'd0;
   localparam logic [CFG_W-1:0] CEILING_RESET = 32'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_TIMEOUT = 2'd0,
      CSR_SLOW_LIMIT = 2'd1,
      CSR_FAST_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_timeout;
      logic [CFG_W-1:0] slow_limit;
      logic [CFG_W-1:0] fast_limit;
   } cfg_type;

   typedef struct packed {
      logic stroke_start;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [TIME_W-1:0] sample_time;
   } item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [TIME_W-1:0] sample_time;
      logic [TIME_W-1:0] gap;
      logic [STEP_W-1:0] step_length;
   } entry_type;

endpackage

@@ hdl/windowed_speed_adaptive_smoother.sv @@
// Top level of the windowed speed adaptive pointer smoother.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_valid/stall     stroke_start, pos_x, pos_y, sample_time
//   rsp_     out        rsp_valid/stall     smooth_x, smooth_y
//   csr_     in         csr_write           csr_index, csr_wdata
//
// A stroke-start beat is handled in the idle state itself. An update beat runs the
// 25-step square root and the radix-2 divider, which runs up to four times; each sample
// that leaves the window is read back from the ring and subtracted from the sums.
// Reset is synchronous; the ring needs no clearing pass after it.
// A two-entry queue takes new beats while the sequencer works, and the result
// register holds a stalled result while the sequencer goes on with the next beat.
`include "assert_macros.svh"

module windowed_speed_adaptive_smoother #(
   parameter int WINDOW_DEPTH = wsas_pkg::WINDOW_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_stroke_start,
   input logic signed [wsas_pkg::POS_W-1:0] req_pos_x,
   input logic signed [wsas_pkg::POS_W-1:0] req_pos_y,
   input logic [wsas_pkg::TIME_W-1:0] req_sample_time,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [wsas_pkg::POS_W-1:0] rsp_smooth_x,
   output logic signed [wsas_pkg::POS_W-1:0] rsp_smooth_y,
   input logic csr_write,
   input logic [wsas_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [wsas_pkg::CFG_W-1:0] csr_wdata
);
   import wsas_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   cfg_type cfg_ff, cfg_in;
   logic q_valid;
   item_type q_item;
   logic q_pop;
   logic [CNT_W-1:0] entry_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_TIMEOUT: cfg_in.window_timeout = csr_wdata;
            CSR_SLOW_LIMIT: cfg_in.slow_limit = csr_wdata;
            CSR_FAST_LIMIT: cfg_in.fast_limit = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_timeout <= TIMEOUT_RESET;
         cfg_ff.slow_limit <= FLOOR_RESET;
         cfg_ff.fast_limit <= CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wsas_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_stroke_start(req_stroke_start),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_sample_time(req_sample_time),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   wsas_back #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_smooth_x(rsp_smooth_x),
      .rsp_smooth_y(rsp_smooth_y),
      .entry_count(entry_count)
   );

   `ASSERT_IMPLIES(a_pop_needs_beat, clock, reset, q_pop, q_valid)
   `ASSERT_IMPLIES(a_count_in_range, clock, reset, 1'b1, entry_count <= CNT_W'(WINDOW_DEPTH))
   `ASSERT_NEXT(a_start_keeps_one, clock, reset, q_pop && q_item.stroke_start, entry_count == CNT_W'(1))
endmodule

@@ hdl/wsas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wsas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/wsas_front.sv @@
// Input queue that takes request beats and hands them to the sequencer.
module wsas_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_stroke_start,
   input logic signed [wsas_pkg::POS_W-1:0] req_pos_x,
   input logic signed [wsas_pkg::POS_W-1:0] req_pos_y,
   input logic [wsas_pkg::TIME_W-1:0] req_sample_time,
   output logic q_valid,
   output wsas_pkg::item_type q_item,
   input logic q_pop
);
   import wsas_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic push;
   item_type beat;

   assign req_stall = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (fill_ff != '0);
   assign q_item = slot_ff[rptr_ff];

   always_comb begin
      beat.stroke_start = req_stroke_start;
      beat.pos_x = req_pos_x;
      beat.pos_y = req_pos_y;
      beat.sample_time = req_sample_time;
   end

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= beat;
      end
   end
endmodule

@@ hdl/wsas_div.sv @@
// Radix-2 restoring divider producing one quotient bit per cycle.
module wsas_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [wsas_pkg::DIV_NUM_W-1:0] dividend,
   input logic [wsas_pkg::DIV_DEN_W-1:0] divisor,
   output logic done,
   output logic [wsas_pkg::DIV_NUM_W-1:0] quotient
);
   import wsas_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0] rem_sh;
   logic ge;
   logic [DIV_DEN_W:0] rem_sub;

   assign rem_sh = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign ge = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = num_ff;
endmodule

@@ hdl/wsas_back.sv @@
// Sequencer that updates the sample ring and sums and computes each result.
module wsas_back #(
   parameter int WINDOW_DEPTH = wsas_pkg::WINDOW_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input wsas_pkg::cfg_type cfg,
   input logic q_valid,
   input wsas_pkg::item_type q_item,
   output logic q_pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic signed [wsas_pkg::POS_W-1:0] rsp_smooth_x,
   output logic signed [wsas_pkg::POS_W-1:0] rsp_smooth_y,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0] entry_count
);
   import wsas_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int ENTRY_W = $bits(entry_type);
   localparam int SQ_W = 2 * (POS_W + 1);
   localparam int ROOT_W = STEP_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
   localparam int PROD_W = POS_W + TIME_W + 1;
   localparam int TOT_W = 64;
   localparam int SPEED_W = CFG_W + 8;
   localparam int T_W = 17;
   localparam int BPROD_W = POS_W + 1 + T_W;
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   typedef enum logic [15:0] {
      S_IDLE = 16'h0001,
      S_SQX = 16'h0002,
      S_SQY = 16'h0004,
      S_SQRT = 16'h0008,
      S_WRITE = 16'h0010,
      S_RD = 16'h0020,
      S_CHK = 16'h0040,
      S_MUL = 16'h0080,
      S_ACC = 16'h0100,
      S_AVGX = 16'h0200,
      S_AVGY = 16'h0400,
      S_SPEED = 16'h0800,
      S_WEIGHT = 16'h1000,
      S_BLEND = 16'h2000,
      S_FINISH = 16'h4000,
      S_OUT = 16'h8000
   } state_type;

   typedef enum logic [2:0] {
      PH_FULL = 3'b001,
      PH_ADD = 3'b010,
      PH_EVICT = 3'b100
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TOT_W-1:0] wx_tot_ff, wx_tot_in;
   logic [TOT_W-1:0] wy_tot_ff, wy_tot_in;
   logic [CFG_W-1:0] len_tot_ff, len_tot_in;
   logic [CFG_W-1:0] gap_tot_ff, gap_tot_in;
   logic div_issued_ff, div_issued_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [POS_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [TIME_W-1:0] cur_time_ff, cur_time_in;
   logic signed [POS_W-1:0] new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic [TIME_W-1:0] new_time_ff, new_time_in;
   logic [SQ_W-1:0] sq_ff, sq_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [SQRT_CNT_W-1:0] sqrt_cnt_ff, sqrt_cnt_in;
   logic [TIME_W-1:0] gap_ff, gap_in;
   entry_type op_ff, op_in;
   logic signed [PROD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [POS_W-1:0] avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [T_W-1:0] t_ff, t_in;
   logic [BPROD_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic bneg_x_ff, bneg_x_in, bneg_y_ff, bneg_y_in;
   logic signed [POS_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_entry;
   logic rd_en;
   logic [ENTRY_W-1:0] rd_data;
   entry_type rd_entry;

   logic div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic div_done;
   logic [DIV_NUM_W-1:0] div_quot;

   logic signed [POS_W:0] dx, dy, mul_a;
   logic signed [SQ_W-1:0] sqr;
   logic [REM_W+1:0] rem_sh, trial;
   logic sqrt_ge;
   logic [REM_W+1:0] rem_sub;
   logic [ROOT_W-1:0] root_next;
   logic [SUM_W-1:0] slot_sum, slot_wrap;
   logic [IDX_W-1:0] slot_idx, oldest_next;
   logic too_old;
   logic signed [PROD_W-1:0] px_prod, py_prod;
   logic [TOT_W-1:0] px_ext, py_ext;
   logic [TOT_W-1:0] mag_x, mag_y;
   logic [TOT_W-1:0] avg_num_x, avg_num_y;
   logic [SPEED_W-1:0] f_ext, c_ext;
   logic w_direct;
   logic [T_W-1:0] w_value;
   logic [CFG_W-1:0] w_diff, w_den;
   logic signed [POS_W:0] dbx, dby;
   logic [POS_W:0] magb_x, magb_y;
   logic [BPROD_W:0] rnd_x, rnd_y;
   logic [POS_W-1:0] r_x, r_y;

   function automatic logic [POS_W-1:0] sat_avg(input logic neg, input logic [TOT_W-1:0] q);
      logic [POS_W-1:0] v;
      if (neg) begin
         v = (q > 64'h800000) ? 24'h800000 : (24'd0 - q[POS_W-1:0]);
      end else begin
         v = (q > 64'h7FFFFF) ? 24'h7FFFFF : q[POS_W-1:0];
      end
      return v;
   endfunction

   wsas_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_ring (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en(rd_en),
      .rd_addr(oldest_ff),
      .rd_data(rd_data)
   );

   wsas_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_num),
      .divisor(div_den),
      .done(div_done),
      .quotient(div_quot)
   );

   assign rd_entry = entry_type'(rd_data);

   assign dx = {cur_x_ff[POS_W-1], cur_x_ff} - {new_x_ff[POS_W-1], new_x_ff};
   assign dy = {cur_y_ff[POS_W-1], cur_y_ff} - {new_y_ff[POS_W-1], new_y_ff};
   assign mul_a = (state_ff == S_SQX) ? dx : dy;
   assign sqr = mul_a * mul_a;

   assign rem_sh = {rem_ff, sq_ff[SQ_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign sqrt_ge = (rem_sh >= trial);
   assign rem_sub = rem_sh - trial;
   assign root_next = {root_ff[ROOT_W-2:0], sqrt_ge};

   assign slot_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff);
   assign slot_wrap = (slot_sum >= SUM_W'(WINDOW_DEPTH)) ?
                      slot_sum - SUM_W'(WINDOW_DEPTH) : slot_sum;
   assign slot_idx = slot_wrap[IDX_W-1:0];
   assign oldest_next = (oldest_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;

   assign too_old = ({1'b0, rd_entry.sample_time} + {1'b0, cfg.window_timeout})
                    < {1'b0, cur_time_ff};

   assign px_prod = $signed(op_ff.pos_x) * $signed({1'b0, op_ff.gap});
   assign py_prod = $signed(op_ff.pos_y) * $signed({1'b0, op_ff.gap});
   assign px_ext = {{(TOT_W - PROD_W){px_ff[PROD_W-1]}}, px_ff};
   assign py_ext = {{(TOT_W - PROD_W){py_ff[PROD_W-1]}}, py_ff};

   assign mag_x = wx_tot_ff[TOT_W-1] ? (64'd0 - wx_tot_ff) : wx_tot_ff;
   assign mag_y = wy_tot_ff[TOT_W-1] ? (64'd0 - wy_tot_ff) : wy_tot_ff;
   assign avg_num_x = mag_x + {32'd0, 1'b0, gap_tot_ff[CFG_W-1:1]};
   assign avg_num_y = mag_y + {32'd0, 1'b0, gap_tot_ff[CFG_W-1:1]};

   assign f_ext = {8'd0, cfg.slow_limit};
   assign c_ext = {8'd0, cfg.fast_limit};

   always_comb begin
      w_direct = 1'b1;
      w_value = '0;
      w_diff = '0;
      w_den = '1;
      if (cfg.slow_limit == cfg.fast_limit) begin
         w_value = (speed_ff > f_ext) ? T_ONE : '0;
      end else if (cfg.fast_limit > cfg.slow_limit) begin
         if (speed_ff <= f_ext) begin
            w_value = '0;
         end else if (speed_ff >= c_ext) begin
            w_value = T_ONE;
         end else begin
            w_direct = 1'b0;
            w_diff = CFG_W'(speed_ff - f_ext);
            w_den = cfg.fast_limit - cfg.slow_limit;
         end
      end else begin
         if (speed_ff >= f_ext) begin
            w_value = '0;
         end else if (speed_ff <= c_ext) begin
            w_value = T_ONE;
         end else begin
            w_direct = 1'b0;
            w_diff = CFG_W'(f_ext - speed_ff);
            w_den = cfg.slow_limit - cfg.fast_limit;
         end
      end
   end

   always_comb begin
      case (state_ff)
         S_AVGX: begin
            div_num = avg_num_x;
            div_den = gap_tot_ff;
         end
         S_AVGY: begin
            div_num = avg_num_y;
            div_den = gap_tot_ff;
         end
         S_SPEED: begin
            div_num = {24'd0, len_tot_ff, 8'd0};
            div_den = gap_tot_ff;
         end
         S_WEIGHT: begin
            div_num = {16'd0, w_diff, 16'd0};
            div_den = w_den;
         end
         default: begin
            div_num = '0;
            div_den = gap_tot_ff;
         end
      endcase
   end

   assign dbx = {cur_x_ff[POS_W-1], cur_x_ff} - {avg_x_ff[POS_W-1], avg_x_ff};
   assign dby = {cur_y_ff[POS_W-1], cur_y_ff} - {avg_y_ff[POS_W-1], avg_y_ff};
   assign magb_x = dbx[POS_W] ? (25'd0 - dbx) : dbx;
   assign magb_y = dby[POS_W] ? (25'd0 - dby) : dby;
   assign rnd_x = {1'b0, bx_ff} + (BPROD_W + 1)'(32768);
   assign rnd_y = {1'b0, by_ff} + (BPROD_W + 1)'(32768);
   assign r_x = rnd_x[16 +: POS_W];
   assign r_y = rnd_y[16 +: POS_W];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      oldest_in = oldest_ff;
      count_in = count_ff;
      wx_tot_in = wx_tot_ff;
      wy_tot_in = wy_tot_ff;
      len_tot_in = len_tot_ff;
      gap_tot_in = gap_tot_ff;
      div_issued_in = div_issued_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_time_in = cur_time_ff;
      new_x_in = new_x_ff;
      new_y_in = new_y_ff;
      new_time_in = new_time_ff;
      sq_in = sq_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      sqrt_cnt_in = sqrt_cnt_ff;
      gap_in = gap_ff;
      op_in = op_ff;
      px_in = px_ff;
      py_in = py_ff;
      avg_x_in = avg_x_ff;
      avg_y_in = avg_y_ff;
      speed_in = speed_ff;
      t_in = t_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      bneg_x_in = bneg_x_ff;
      bneg_y_in = bneg_y_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = slot_idx;
      wr_entry.pos_x = cur_x_ff;
      wr_entry.pos_y = cur_y_ff;
      wr_entry.sample_time = cur_time_ff;
      wr_entry.gap = gap_ff;
      wr_entry.step_length = root_ff;
      rd_en = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.stroke_start) begin
                  wr_en = 1'b1;
                  wr_addr = '0;
                  wr_entry.pos_x = q_item.pos_x;
                  wr_entry.pos_y = q_item.pos_y;
                  wr_entry.sample_time = q_item.sample_time;
                  wr_entry.gap = '0;
                  wr_entry.step_length = '0;
                  oldest_in = '0;
                  count_in = CNT_W'(1);
                  wx_tot_in = '0;
                  wy_tot_in = '0;
                  len_tot_in = '0;
                  gap_tot_in = '0;
                  new_x_in = q_item.pos_x;
                  new_y_in = q_item.pos_y;
                  new_time_in = q_item.sample_time;
               end else begin
                  cur_x_in = q_item.pos_x;
                  cur_y_in = q_item.pos_y;
                  cur_time_in = q_item.sample_time;
                  state_in = S_SQX;
               end
            end
         end
         S_SQX: begin
            sq_in = SQ_W'(sqr);
            gap_in = (count_ff != '0) ? cur_time_ff - new_time_ff : '0;
            state_in = S_SQY;
         end
         S_SQY: begin
            sq_in = sq_ff + SQ_W'(sqr);
            root_in = '0;
            rem_in = '0;
            sqrt_cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            sq_in = {sq_ff[SQ_W-3:0], 2'b00};
            root_in = root_next;
            rem_in = sqrt_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            sqrt_cnt_in = sqrt_cnt_ff + 1'b1;
            if (sqrt_cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
               root_in = (count_ff != '0) ? root_next : '0;
               if (count_ff == CNT_W'(WINDOW_DEPTH)) begin
                  phase_in = PH_FULL;
                  state_in = S_RD;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            wr_en = 1'b1;
            count_in = count_ff + 1'b1;
            new_x_in = cur_x_ff;
            new_y_in = cur_y_ff;
            new_time_in = cur_time_ff;
            op_in = wr_entry;
            phase_in = PH_ADD;
            state_in = S_MUL;
         end
         S_RD: begin
            rd_en = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (phase_ff == PH_FULL || (count_ff != '0 && too_old)) begin
               op_in = rd_entry;
               state_in = S_MUL;
            end else if (gap_tot_ff == '0) begin
               res_x_in = cur_x_ff;
               res_y_in = cur_y_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_AVGX;
            end
         end
         S_MUL: begin
            px_in = px_prod;
            py_in = py_prod;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (phase_ff == PH_ADD) begin
               wx_tot_in = wx_tot_ff + px_ext;
               wy_tot_in = wy_tot_ff + py_ext;
               len_tot_in = len_tot_ff + CFG_W'(op_ff.step_length);
               gap_tot_in = gap_tot_ff + op_ff.gap;
               phase_in = PH_EVICT;
               state_in = S_RD;
            end else begin
               wx_tot_in = wx_tot_ff - px_ext;
               wy_tot_in = wy_tot_ff - py_ext;
               len_tot_in = len_tot_ff - CFG_W'(op_ff.step_length);
               gap_tot_in = gap_tot_ff - op_ff.gap;
               oldest_in = oldest_next;
               count_in = count_ff - 1'b1;
               state_in = (phase_ff == PH_FULL) ? S_WRITE : S_RD;
            end
         end
         S_AVGX: begin
            if (!div_issued_ff) begin
               div_start = 1'b1;
               div_issued_in = 1'b1;
            end else if (div_done) begin
               div_issued_in = 1'b0;
               avg_x_in = sat_avg(wx_tot_ff[TOT_W-1], div_quot);
               state_in = S_AVGY;
            end
         end
         S_AVGY: begin
            if (!div_issued_ff) begin
               div_start = 1'b1;
               div_issued_in = 1'b1;
            end else if (div_done) begin
               div_issued_in = 1'b0;
               avg_y_in = sat_avg(wy_tot_ff[TOT_W-1], div_quot);
               state_in = S_SPEED;
            end
         end
         S_SPEED: begin
            if (!div_issued_ff) begin
               div_start = 1'b1;
               div_issued_in = 1'b1;
            end else if (div_done) begin
               div_issued_in = 1'b0;
               speed_in = div_quot[SPEED_W-1:0];
               state_in = S_WEIGHT;
            end
         end
         S_WEIGHT: begin
            if (!div_issued_ff) begin
               if (w_direct) begin
                  t_in = w_value;
                  state_in = S_BLEND;
               end else begin
                  div_start = 1'b1;
                  div_issued_in = 1'b1;
               end
            end else if (div_done) begin
               div_issued_in = 1'b0;
               t_in = div_quot[T_W-1:0];
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            bx_in = magb_x * t_ff;
            by_in = magb_y * t_ff;
            bneg_x_in = dbx[POS_W];
            bneg_y_in = dby[POS_W];
            state_in = S_FINISH;
         end
         S_FINISH: begin
            res_x_in = bneg_x_ff ? avg_x_ff - r_x : avg_x_ff + r_x;
            res_y_in = bneg_y_ff ? avg_y_ff - r_y : avg_y_ff + r_y;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = res_x_ff;
               rsp_y_in = res_y_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_ADD;
         oldest_ff <= '0;
         count_ff <= '0;
         wx_tot_ff <= '0;
         wy_tot_ff <= '0;
         len_tot_ff <= '0;
         gap_tot_ff <= '0;
         div_issued_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         oldest_ff <= oldest_in;
         count_ff <= count_in;
         wx_tot_ff <= wx_tot_in;
         wy_tot_ff <= wy_tot_in;
         len_tot_ff <= len_tot_in;
         gap_tot_ff <= gap_tot_in;
         div_issued_ff <= div_issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      cur_time_ff <= cur_time_in;
      new_x_ff <= new_x_in;
      new_y_ff <= new_y_in;
      new_time_ff <= new_time_in;
      sq_ff <= sq_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      sqrt_cnt_ff <= sqrt_cnt_in;
      gap_ff <= gap_in;
      op_ff <= op_in;
      px_ff <= px_in;
      py_ff <= py_in;
      avg_x_ff <= avg_x_in;
      avg_y_ff <= avg_y_in;
      speed_ff <= speed_in;
      t_ff <= t_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      bneg_x_ff <= bneg_x_in;
      bneg_y_ff <= bneg_y_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_smooth_x = rsp_x_ff;
   assign rsp_smooth_y = rsp_y_ff;
   assign entry_count = count_ff;
endmodule

@@ tb/sv/tb_windowed_speed_adaptive_smoother.sv @@
// Self-checking testbench for the windowed speed adaptive smoother, with its own predictor.
`timescale 1ns / 100ps

module tb_windowed_speed_adaptive_smoother;
   import wsas_pkg::*;

   localparam int DEPTH = WINDOW_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 1200;
   localparam int EXP_DEPTH = 1024;

   typedef struct {
      logic signed [POS_W-1:0] sx;
      logic signed [POS_W-1:0] sy;
   } point_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_stroke_start;
   logic signed [POS_W-1:0] req_pos_x;
   logic signed [POS_W-1:0] req_pos_y;
   logic [TIME_W-1:0] req_sample_time;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [POS_W-1:0] rsp_smooth_x;
   logic signed [POS_W-1:0] rsp_smooth_y;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   windowed_speed_adaptive_smoother dut (.*);

   // Predictor state.
   logic signed [POS_W-1:0] win_x [DEPTH];
   logic signed [POS_W-1:0] win_y [DEPTH];
   logic [31:0] win_stamp [DEPTH];
   logic [31:0] win_gap [DEPTH];
   logic [31:0] win_len [DEPTH];
   int unsigned head_slot;
   int unsigned fill;
   logic [63:0] sum_wx;
   logic [63:0] sum_wy;
   logic [31:0] sum_len;
   logic [31:0] sum_gap;
   cfg_type cfg;

   point_type exp_buf [EXP_DEPTH];
   int unsigned exp_wr;
   int unsigned exp_rd;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_cycles;
   int unsigned beats_sent;
   int unsigned results_seen;
   int unsigned failures;
   logic signed [POS_W-1:0] cur_x;
   logic signed [POS_W-1:0] cur_y;
   logic [31:0] cur_stamp;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic void account_entry(int unsigned s, bit add);
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] pg;
      px = win_x[s];
      py = win_y[s];
      pg = {32'b0, win_gap[s]};
      if (add) begin
         sum_wx += px * pg;
         sum_wy += py * pg;
         sum_len += win_len[s];
         sum_gap += win_gap[s];
      end else begin
         sum_wx -= px * pg;
         sum_wy -= py * pg;
         sum_len -= win_len[s];
         sum_gap -= win_gap[s];
      end
   endfunction

   function automatic void evict_oldest();
      account_entry(head_slot, 1'b0);
      head_slot = (head_slot + 1) % DEPTH;
      fill--;
   endfunction

   function automatic logic signed [63:0] weighted_mean(logic [63:0] w, logic [31:0] d);
      logic [63:0] mag;
      logic [63:0] q;
      mag = w[63] ? -w : w;
      q = (mag + {33'b0, d[31:1]}) / {32'b0, d};
      if (w[63]) return (q > 64'h800000) ? -64'sh800000 : -$signed(q);
      return (q > 64'h7FFFFF) ? 64'sh7FFFFF : $signed(q);
   endfunction

   function automatic logic [63:0] raw_weight(logic [63:0] speed);
      logic [63:0] f;
      logic [63:0] c;
      f = {32'b0, cfg.slow_limit};
      c = {32'b0, cfg.fast_limit};
      if (f == c) return (speed > f) ? 64'd65536 : 64'd0;
      if (c > f) begin
         if (speed <= f) return 0;
         if (speed >= c) return 65536;
         return ((speed - f) << 16) / (c - f);
      end
      if (speed >= f) return 0;
      if (speed <= c) return 65536;
      return ((f - speed) << 16) / (f - c);
   endfunction

   function automatic logic signed [POS_W-1:0] pull_toward(logic signed [63:0] mean,
                                                            logic signed [63:0] pos,
                                                            logic [63:0] w);
      logic signed [63:0] d;
      logic [63:0] mag;
      logic signed [63:0] r;
      d = pos - mean;
      mag = d < 0 ? -d : d;
      r = $signed((mag * w + 64'd32768) >> 16);
      return (d < 0) ? POS_W'(mean - r) : POS_W'(mean + r);
   endfunction

   function automatic void predict_beat(logic start, logic signed [POS_W-1:0] x,
                                        logic signed [POS_W-1:0] y, logic [31:0] stamp);
      logic [31:0] gap;
      logic [31:0] len;
      int unsigned s;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] mx;
      logic signed [63:0] my;
      logic [63:0] w;
      point_type p;
      gap = 0;
      len = 0;
      if (start) begin
         head_slot = 0;
         fill = 1;
         sum_wx = 0;
         sum_wy = 0;
         sum_len = 0;
         sum_gap = 0;
         win_x[0] = x;
         win_y[0] = y;
         win_stamp[0] = stamp;
         win_gap[0] = 0;
         win_len[0] = 0;
         return;
      end
      if (fill > 0) begin
         s = (head_slot + fill - 1) % DEPTH;
         dx = 64'(x) - 64'(win_x[s]);
         dy = 64'(y) - 64'(win_y[s]);
         gap = stamp - win_stamp[s];
         len = int_sqrt(dx * dx + dy * dy);
      end
      if (fill >= DEPTH) evict_oldest();
      s = (head_slot + fill) % DEPTH;
      win_x[s] = x;
      win_y[s] = y;
      win_stamp[s] = stamp;
      win_gap[s] = gap;
      win_len[s] = len;
      fill++;
      account_entry(s, 1'b1);
      while (fill > 0 && ({1'b0, win_stamp[head_slot]} + {1'b0, cfg.window_timeout})
             < {1'b0, stamp})
         evict_oldest();
      if (sum_gap == 0) begin
         p.sx = x;
         p.sy = y;
      end else begin
         mx = weighted_mean(sum_wx, sum_gap);
         my = weighted_mean(sum_wy, sum_gap);
         w = raw_weight(({32'b0, sum_len} << 8) / {32'b0, sum_gap});
         p.sx = pull_toward(mx, 64'(x), w);
         p.sy = pull_toward(my, 64'(y), w);
      end
      exp_buf[exp_wr % EXP_DEPTH] = p;
      exp_wr++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected result x=%0d y=%0d", $time, rsp_smooth_x,
                     rsp_smooth_y);
            failures++;
         end else begin
            if (rsp_smooth_x !== exp_buf[exp_rd % EXP_DEPTH].sx) begin
               $display("%0t: smooth_x expected %0d actual %0d", $time,
                        exp_buf[exp_rd % EXP_DEPTH].sx, rsp_smooth_x);
               failures++;
            end
            if (rsp_smooth_y !== exp_buf[exp_rd % EXP_DEPTH].sy) begin
               $display("%0t: smooth_y expected %0d actual %0d", $time,
                        exp_buf[exp_rd % EXP_DEPTH].sy, rsp_smooth_y);
               failures++;
            end
            exp_rd++;
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_beat(logic start, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_stroke_start = start;
      req_pos_x = x;
      req_pos_y = y;
      req_sample_time = stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(start, x, y, stamp);
      beats_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CFG_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_WINDOW_TIMEOUT: cfg.window_timeout = value;
         CSR_SLOW_LIMIT: cfg.slow_limit = value;
         default: cfg.fast_limit = value;
      endcase
   endtask

   task automatic set_config(logic [31:0] timeout, logic [31:0] floor_v, logic [31:0] ceil_v);
      drain();
      write_reg(CSR_WINDOW_TIMEOUT, timeout);
      write_reg(CSR_SLOW_LIMIT, floor_v);
      write_reg(CSR_FAST_LIMIT, ceil_v);
   endtask

   task automatic start_stroke(logic full_range);
      cur_x = full_range ? POS_W'($urandom) : POS_W'($urandom_range(0, 40000) - 20000);
      cur_y = full_range ? POS_W'($urandom) : POS_W'($urandom_range(0, 40000) - 20000);
      cur_stamp = $urandom;
      send_beat(1'b1, cur_x, cur_y, cur_stamp);
   endtask

   task automatic next_sample();
      int unsigned span;
      int unsigned pick;
      span = 1 << $urandom_range(0, 16);
      pick = $urandom_range(99);
      cur_x += POS_W'($urandom_range(0, 2 * span) - span);
      cur_y += POS_W'($urandom_range(0, 2 * span) - span);
      if (pick < 3) cur_stamp -= $urandom_range(1, 5000);
      else if (pick < 6) cur_stamp += $urandom;
      else cur_stamp += $urandom_range(0, 1 << $urandom_range(0, 15));
      send_beat(1'b0, cur_x, cur_y, cur_stamp);
   endtask

   task automatic random_stroke(int unsigned length);
      start_stroke($urandom_range(3) == 0);
      repeat (length) begin
         if ($urandom_range(99) < 4) send_beat(1'($urandom_range(1)), POS_W'($urandom),
                                               POS_W'($urandom), $urandom);
         else next_sample();
      end
   endtask

   task automatic test_directed();
      set_config(TIMEOUT_RESET, FLOOR_RESET, CEILING_RESET);
      send_beat(1'b0, 24'sh7FFFFF, -24'sh800000, 32'hFFFFFFFF);
      send_beat(1'b0, -24'sh800000, 24'sh7FFFFF, 32'd0);
      send_beat(1'b1, 24'sd0, 24'sd0, 32'd100);
      send_beat(1'b0, 24'sd0, 24'sd0, 32'd100);
      send_beat(1'b0, 24'sd256, 24'sd0, 32'd1100);
      send_beat(1'b0, 24'sd512, 24'sd256, 32'd2100);
      send_beat(1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 32'd2200);
      send_beat(1'b0, -24'sh800000, -24'sh800000, 32'd2300);
      send_beat(1'b0, 24'sd1000, -24'sd1000, 32'd1000);
      send_beat(1'b0, 24'sd1010, -24'sd1000, 32'd900000);
      send_beat(1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 32'hFFFFFFF0);
      send_beat(1'b0, -24'sh800000, -24'sh800000, 32'hFFFFFFFF);
      send_beat(1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 32'h0000000F);
      send_beat(1'b0, 24'sd0, 24'sd0, 32'h00000010);
   endtask

   task automatic test_config_extremes();
      set_config(32'd0, 32'd100, 32'd100);
      random_stroke(6);
      set_config(32'hFFFFFFFF, 32'd5000, 32'd50);
      random_stroke(8);
      set_config(32'd20000, 32'hFFFFFFFF, 32'd0);
      random_stroke(6);
      set_config(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF);
      random_stroke(6);
      set_config(32'hFFFFFFFF, 32'd0, 32'd0);
      random_stroke(70);
   endtask

   task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_p,
                                    int unsigned beats);
      int unsigned stop_at;
      logic [31:0] lo;
      send_idle_pct = idle_pct;
      stall_pct = stall_p;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         lo = $urandom_range(0, 3000);
         set_config(($urandom_range(3) == 0) ? 32'hFFFFFFFF : $urandom_range(0, 200000),
                    lo, ($urandom_range(4) == 0) ? lo : $urandom_range(0, 8000));
         random_stroke($urandom_range(1, 40));
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      set_config(32'hFFFFFFFF, 32'd0, 32'd2000);
      hold_cycles = 4000;
      random_stroke(12);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_stroke_start = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_sample_time = '0;
      csr_write = 1'b0;
      csr_index = CSR_WINDOW_TIMEOUT;
      csr_wdata = '0;
      exp_wr = 0;
      exp_rd = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      beats_sent = 0;
      results_seen = 0;
      failures = 0;
      head_slot = 0;
      fill = 0;
      sum_wx = 0;
      sum_wy = 0;
      sum_len = 0;
      sum_gap = 0;
      cfg.window_timeout = TIMEOUT_RESET;
      cfg.slow_limit = FLOOR_RESET;
      cfg.fast_limit = CEILING_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_config_extremes();
      test_random_phase(0, 0, 70);
      test_random_phase(88, 0, 60);
      test_random_phase(0, 88, 60);
      test_random_phase(35, 35, 60);
      test_backpressure();
      drain();

      $display("Sent %0d beats and checked %0d smoothed points across", beats_sent,
               results_seen);
      $display("window, speed and idling settings, with %0d mismatches.", failures);
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
